>>> rtl/core/dq_pkg.sv
// Shared constants, types and helpers for the double-ended queue.
package dq_pkg;

  localparam int unsigned Depth   = 1024;
  localparam int unsigned AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam int unsigned CntOutW = 11;
  localparam int unsigned WordW   = 32;

  typedef logic [AddrW-1:0]          addr_t;
  typedef logic [CntW-1:0]           cnt_t;
  typedef logic signed [WordW-1:0]   word_t;

  localparam word_t WordNone = '1;

  typedef enum logic [2:0] {
    OpNone      = 3'd0,
    OpPushFront = 3'd1,
    OpPushBack  = 3'd2,
    OpPopFront  = 3'd3,
    OpPopBack   = 3'd4
  } op_e;

  // RAM request from the controller
  typedef struct packed {
    logic  we;
    logic  re;
    addr_t addr;
    word_t wdata;
  } mem_req_t;

  // One finished result
  typedef struct packed {
    word_t              popped;
    logic [CntOutW-1:0] count;
    logic               is_empty;
    word_t              front_value;
    word_t              back_value;
    logic               overflow;
  } result_t;

  // Fit the internal count to the 11-bit result field
  function automatic logic [CntOutW-1:0] cnt_out(input cnt_t c);
    logic [CntOutW+CntW-1:0] ext;
    ext = {{CntOutW{1'b0}}, c};
    return ext[CntOutW-1:0];
  endfunction

  function automatic addr_t ring_next(input addr_t i);
    return (i == addr_t'(Depth - 1)) ? '0 : addr_t'(i + addr_t'(1));
  endfunction

  function automatic addr_t ring_prev(input addr_t i);
    return (i == '0) ? addr_t'(Depth - 1) : addr_t'(i - addr_t'(1));
  endfunction

endpackage

>>> rtl/core/double_ended_queue.sv
// Top level: double-ended queue with a ring RAM and a registered result stage.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------------
//   in      | input     | in_valid_i / in_ready_o | operation_i, value_i
//   out     | output    | out_valid_o/out_ready_i | popped_o, count_o, is_empty_o,
//           |           |                         | front_value_o, back_value_o,
//           |           |                         | overflow_o
//
// A no-op, a push, or a pop that leaves fewer than two entries gives its result
// when accepted. A pop that leaves two or more entries waits in StFill while
// the new front or back word is read from the single-port RAM (registered read).
// Reset clears pointers and count; the RAM is not cleared and needs no sweep.
// The result register frees the input side; a new transfer is taken while the
// held result is taken in the same cycle.
module double_ended_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    operation_i,
  input  logic signed [31:0] value_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic signed [31:0] popped_o,
  output logic [10:0]   count_o,
  output logic          is_empty_o,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] back_value_o,
  output logic          overflow_o
);
  import dq_pkg::*;

  logic     out_valid_q;
  result_t  out_q;
  logic     slot_free;
  logic     res_valid;
  result_t  res;
  mem_req_t mem_req;
  word_t    mem_rdata;

  assign slot_free = !out_valid_q || out_ready_i;

  dq_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .operation_i,
    .value_i,
    .slot_free_i (slot_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  dq_ram u_ram (
    .clk_i,
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign popped_o      = out_q.popped;
  assign count_o       = out_q.count;
  assign is_empty_o    = out_q.is_empty;
  assign front_value_o = out_q.front_value;
  assign back_value_o  = out_q.back_value;
  assign overflow_o    = out_q.overflow;

endmodule

>>> rtl/core/dq_ram.sv
// Single-port ring storage with registered read data.
module dq_ram (
  input  logic             clk_i,
  input  dq_pkg::mem_req_t req_i,
  output dq_pkg::word_t    rdata_o
);
  import dq_pkg::*;

  word_t mem_q [Depth];
  word_t rdata_q;

  // One access per cycle: write or read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/dq_ctrl.sv
// Pointer, count and end-word control; refills a cached end word after a pop.
module dq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       operation_i,
  input  dq_pkg::word_t    value_i,
  input  logic             slot_free_i,
  output logic             res_valid_o,
  output dq_pkg::result_t  res_o,
  output dq_pkg::mem_req_t mem_req_o,
  input  dq_pkg::word_t    mem_rdata_i
);
  import dq_pkg::*;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StFill = 2'b10
  } state_e;

  state_e state_q, state_d;
  addr_t  head_q, head_d, tail_q, tail_d;
  cnt_t   count_q, count_d;
  word_t  front_q, front_d, back_q, back_d;
  word_t  popped_q, popped_d;
  logic   fill_front_q, fill_front_d;
  logic   ovf;
  logic   accept, full, empty, need_read;

  assign in_ready_o = (state_q == StIdle) && slot_free_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == cnt_t'(Depth));
  assign empty      = (count_q == '0);

  // Next-state logic
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    front_d      = front_q;
    back_d       = back_q;
    popped_d     = popped_q;
    fill_front_d = fill_front_q;
    ovf          = 1'b0;
    need_read    = 1'b0;
    mem_req_o    = '{we: 1'b0, re: 1'b0, addr: '0, wdata: value_i};

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          popped_d = '0;
          unique case (operation_i)
            OpPushFront: begin
              if (full) begin
                ovf = 1'b1;
              end else begin
                head_d         = ring_prev(head_q);
                mem_req_o.we   = 1'b1;
                mem_req_o.addr = ring_prev(head_q);
                front_d        = value_i;
                if (empty) back_d = value_i;
                count_d        = cnt_t'(count_q + cnt_t'(1));
              end
            end
            OpPushBack: begin
              if (full) begin
                ovf = 1'b1;
              end else begin
                tail_d         = ring_next(tail_q);
                mem_req_o.we   = 1'b1;
                mem_req_o.addr = tail_q;
                back_d         = value_i;
                if (empty) front_d = value_i;
                count_d        = cnt_t'(count_q + cnt_t'(1));
              end
            end
            OpPopFront: begin
              if (empty) begin
                popped_d = WordNone;
              end else begin
                popped_d = front_q;
                head_d   = ring_next(head_q);
                count_d  = cnt_t'(count_q - cnt_t'(1));
                if (count_q == cnt_t'(2)) begin
                  front_d = back_q;
                end else if (count_q > cnt_t'(2)) begin
                  need_read      = 1'b1;
                  mem_req_o.re   = 1'b1;
                  mem_req_o.addr = ring_next(head_q);
                  fill_front_d   = 1'b1;
                end
              end
            end
            OpPopBack: begin
              if (empty) begin
                popped_d = WordNone;
              end else begin
                popped_d = back_q;
                tail_d   = ring_prev(tail_q);
                count_d  = cnt_t'(count_q - cnt_t'(1));
                if (count_q == cnt_t'(2)) begin
                  back_d = front_q;
                end else if (count_q > cnt_t'(2)) begin
                  need_read      = 1'b1;
                  mem_req_o.re   = 1'b1;
                  mem_req_o.addr = ring_prev(ring_prev(tail_q));
                  fill_front_d   = 1'b0;
                end
              end
            end
            default: ;  // none and unused codes
          endcase
          if (need_read) state_d = StFill;
        end
      end
      StFill: begin
        // read data for the new end word has arrived
        if (fill_front_q) front_d = mem_rdata_i;
        else              back_d  = mem_rdata_i;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Result from the post-operation state
  assign res_valid_o = (accept && !need_read) || (state_q == StFill);

  always_comb begin
    res_o.popped      = popped_d;
    res_o.count       = cnt_out(count_d);
    res_o.is_empty    = (count_d == '0);
    res_o.front_value = (count_d == '0) ? WordNone : front_d;
    res_o.back_value  = (count_d == '0) ? WordNone : back_d;
    res_o.overflow    = ovf;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Cached end words and pop holding
  always_ff @(posedge clk_i) begin
    front_q      <= front_d;
    back_q       <= back_d;
    popped_q     <= popped_d;
    fill_front_q <= fill_front_d;
  end

endmodule
